@@ hw/rtl/fun_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fun_pkg
// Widths and types shared by the face unit normal pipeline.
// ----------------------------------------------------------------------------
package fun_pkg;
  localparam int CW  = 24;          // coordinate width
  localparam int F   = 30;          // normal fraction bits
  localparam int NW  = 32;          // normal output width
  localparam int DW  = CW + 1;      // edge vector width
  localparam int PW  = 2 * DW;      // product width
  localparam int MW  = PW;          // cross product magnitude width
  localparam int HW  = MW / 2;      // half of a magnitude
  localparam int SW  = 2 * MW + 2;  // sum of squares width
  localparam int RW  = MW + 1;      // root width
  localparam int QW  = F + 1;       // quotient width

  localparam logic [1:0] AXIS_X = 2'd1;
  localparam logic [1:0] AXIS_Y = 2'd2;
  localparam logic [1:0] AXIS_Z = 2'd3;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } fun_item_t;
endpackage

@@ hw/rtl/face_unit_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_unit_normal
// Q1.30 unit normal of a face from four face midpoints.
//
// The input channel takes one beat per face: the x, y and z coordinates of
// the start and end midpoints of the eta and xi edges. The output channel
// gives the unit normal, the axis of its largest component and a flag for a
// face of zero area, whose normal is zero.
// The block is a single pipeline that takes one beat every cycle unless the
// receiver stalls. Six stages form the cross product and its sum of squares,
// the square root resolves one root bit per stage, the divider one quotient
// bit per stage, and an output register holds the result.
// When the receiver stalls, the whole pipeline holds and in_ready falls, so
// no beat is lost or repeated. Reset clears all valid bits; the pipeline is
// empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module face_unit_normal import fun_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_eta_start_x,
  input  logic signed [CW-1:0] in_eta_end_x,
  input  logic signed [CW-1:0] in_xi_start_x,
  input  logic signed [CW-1:0] in_xi_end_x,
  input  logic signed [CW-1:0] in_eta_start_y,
  input  logic signed [CW-1:0] in_eta_end_y,
  input  logic signed [CW-1:0] in_xi_start_y,
  input  logic signed [CW-1:0] in_xi_end_y,
  input  logic signed [CW-1:0] in_eta_start_z,
  input  logic signed [CW-1:0] in_eta_end_z,
  input  logic signed [CW-1:0] in_xi_start_z,
  input  logic signed [CW-1:0] in_xi_end_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [NW-1:0] out_normal_x,
  output logic signed [NW-1:0] out_normal_y,
  output logic signed [NW-1:0] out_normal_z,
  output logic [1:0]           out_largest_axis,
  output logic                 out_zero_area
);
  logic en;
  logic [5:0][CW-1:0] st, nd;
  logic f_v, s_v, d_v;
  logic [SW-1:0] sum;
  fun_item_t f_item, s_item;
  logic [RW-1:0] len;
  logic [2:0][QW-1:0] quo;
  logic [2:0] neg;
  logic zero;
  logic out_valid_r;
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic [1:0] axis_r;
  logic zero_r;
  logic [2:0][NW-1:0] n_nxt;
  logic [1:0] axis_nxt;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  assign st = {in_xi_start_z, in_eta_start_z, in_xi_start_y, in_eta_start_y,
               in_xi_start_x, in_eta_start_x};
  assign nd = {in_xi_end_z, in_eta_end_z, in_xi_end_y, in_eta_end_y,
               in_xi_end_x, in_eta_end_x};

  fun_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid), .st(st), .nd(nd),
    .out_v(f_v), .sum(sum), .item(f_item)
  );

  fun_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(f_v), .sum(sum), .in_item(f_item),
    .out_v(s_v), .root(len), .out_item(s_item)
  );

  fun_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(s_v), .len(len), .in_item(s_item),
    .out_v(d_v), .quo(quo), .neg(neg), .zero(zero)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = neg[i] ? -NW'(quo[i]) : NW'(quo[i]);
      if (zero) begin
        n_nxt[i] = '0;
      end
    end
    axis_nxt = AXIS_X;
    if (!zero) begin
      priority if (quo[2] > quo[0] && quo[2] > quo[1]) begin
        axis_nxt = AXIS_Z;
      end else if (quo[1] > quo[0]) begin
        axis_nxt = AXIS_Y;
      end else begin
        axis_nxt = AXIS_X;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en && d_v) begin
      nx_r   <= n_nxt[0];
      ny_r   <= n_nxt[1];
      nz_r   <= n_nxt[2];
      axis_r <= axis_nxt;
      zero_r <= zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normal_x     = nx_r;
  assign out_normal_y     = ny_r;
  assign out_normal_z     = nz_r;
  assign out_largest_axis = axis_r;
  assign out_zero_area    = zero_r;
endmodule

@@ hw/rtl/fun_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fun_front
// Edge vectors, cross product, magnitudes and the sum of their squares.
// ----------------------------------------------------------------------------
module fun_front import fun_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [5:0][CW-1:0]   st,
  input  logic [5:0][CW-1:0]   nd,
  output logic                 out_v,
  output logic [SW-1:0]        sum,
  output fun_item_t            item
);
  logic [5:0] v_r;
  logic signed [DW-1:0] d_r [6];
  logic signed [PW-1:0] p_r [6];
  fun_item_t it3_r, it4_r, it5_r, it6_r;
  logic [2:0][MW-1:0] hh_r, hl_r, ll_r;
  logic [2:0][2*MW-1:0] sq_r;
  logic [SW-1:0] sum_r;
  logic signed [PW:0] c_nxt [3];
  logic [2:0][MW-1:0] mag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_comb begin
    c_nxt[0] = {p_r[0][PW-1], p_r[0]} - {p_r[1][PW-1], p_r[1]};
    c_nxt[1] = {p_r[2][PW-1], p_r[2]} - {p_r[3][PW-1], p_r[3]};
    c_nxt[2] = {p_r[4][PW-1], p_r[4]} - {p_r[5][PW-1], p_r[5]};
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = c_nxt[i][PW] ? MW'(-c_nxt[i]) : MW'(c_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        d_r[i] <= $signed({nd[i][CW-1], nd[i]}) - $signed({st[i][CW-1], st[i]});
      end
      // d order: ex, xx, ey, xy, ez, xz
      p_r[0] <= d_r[3] * d_r[4];
      p_r[1] <= d_r[5] * d_r[2];
      p_r[2] <= d_r[5] * d_r[0];
      p_r[3] <= d_r[1] * d_r[4];
      p_r[4] <= d_r[1] * d_r[2];
      p_r[5] <= d_r[3] * d_r[0];
      for (int i = 0; i < 3; i++) begin
        it3_r.mag[i] <= mag_nxt[i];
        it3_r.neg[i] <= c_nxt[i][PW];
      end
      it3_r.zero <= (mag_nxt == '0);
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= it3_r.mag[i][MW-1:HW] * it3_r.mag[i][MW-1:HW];
        hl_r[i] <= it3_r.mag[i][MW-1:HW] * it3_r.mag[i][HW-1:0];
        ll_r[i] <= it3_r.mag[i][HW-1:0] * it3_r.mag[i][HW-1:0];
      end
      it4_r <= it3_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {hh_r[i], ll_r[i]} + ((2*MW)'(hl_r[i]) << (HW + 1));
      end
      it5_r <= it4_r;
      sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      it6_r <= it5_r;
    end
  end

  assign out_v = v_r[5];
  assign sum   = sum_r;
  assign item  = it6_r;
endmodule

@@ hw/rtl/fun_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fun_sqrt
// Floor square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module fun_sqrt import fun_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [SW-1:0] sum,
  input  fun_item_t     in_item,
  output logic          out_v,
  output logic [RW-1:0] root,
  output fun_item_t     out_item
);
  logic            v_r    [RW];
  logic [SW-1:0]   s_r    [RW];
  logic [RW-1:0]   root_r [RW];
  logic [RW:0]     rem_r  [RW];
  fun_item_t       it_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            sv;
    logic [SW-1:0]   ss;
    logic [RW-1:0]   sroot;
    logic [RW:0]     srem;
    fun_item_t       sit;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    if (k == 0) begin : g_first
      assign sv = in_v;
      assign ss = sum;
      assign sroot = '0;
      assign srem = '0;
      assign sit = in_item;
    end else begin : g_next
      assign sv = v_r[k-1];
      assign ss = s_r[k-1];
      assign sroot = root_r[k-1];
      assign srem = rem_r[k-1];
      assign sit = it_r[k-1];
    end
    assign rem2  = {srem, ss[SW-1-2*k -: 2]};
    assign trial = {1'b0, sroot, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]  <= ss;
        it_r[k] <= sit;
        if (rem2 >= trial) begin
          rem_r[k]  <= (RW+1)'(rem2 - trial);
          root_r[k] <= {sroot[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= (RW+1)'(rem2);
          root_r[k] <= {sroot[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v    = v_r[RW-1];
  assign root     = root_r[RW-1];
  assign out_item = it_r[RW-1];
endmodule

@@ hw/rtl/fun_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fun_div
// Three-lane restoring divider of magnitude times 2^F by the length,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module fun_div import fun_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [RW-1:0]       len,
  input  fun_item_t           in_item,
  output logic                out_v,
  output logic [2:0][QW-1:0]  quo,
  output logic [2:0]          neg,
  output logic                zero
);
  logic                v_r   [QW];
  logic [RW-1:0]       len_r [QW];
  logic [2:0][RW-1:0]  rem_r [QW];
  logic [2:0][QW-1:0]  q_r   [QW];
  logic [2:0]          neg_r [QW];
  logic                z_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic               sv;
    logic [RW-1:0]      slen;
    logic [2:0][RW-1:0] srem;
    logic [2:0][QW-1:0] sq;
    logic [2:0]         sneg;
    logic               sz;
    logic [2:0]         nbit;
    if (j == 0) begin : g_first
      assign sv   = in_v;
      assign slen = len;
      assign sq   = '0;
      assign sneg = in_item.neg;
      assign sz   = in_item.zero;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign srem[i] = {2'b00, in_item.mag[i][MW-1:1]};
        assign nbit[i] = in_item.mag[i][0];
      end
    end else begin : g_next
      assign sv   = v_r[j-1];
      assign slen = len_r[j-1];
      assign srem = rem_r[j-1];
      assign sq   = q_r[j-1];
      assign sneg = neg_r[j-1];
      assign sz   = z_r[j-1];
      assign nbit = '0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      logic [RW:0] rem2;
      if (en) begin
        len_r[j] <= slen;
        neg_r[j] <= sneg;
        z_r[j]   <= sz;
        for (int i = 0; i < 3; i++) begin
          rem2 = {srem[i], nbit[i]};
          if (rem2 >= {1'b0, slen}) begin
            rem_r[j][i] <= RW'(rem2 - {1'b0, slen});
            q_r[j][i]   <= {sq[i][QW-2:0], 1'b1};
          end else begin
            rem_r[j][i] <= RW'(rem2);
            q_r[j][i]   <= {sq[i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_v = v_r[QW-1];
  assign quo   = q_r[QW-1];
  assign neg   = neg_r[QW-1];
  assign zero  = z_r[QW-1];
endmodule
